// ===== hdl/lprt_pkg.sv =====
// Package: shared constants, types and codes of the linear probe record table.
`timescale 1ns / 1ps

package lprt_pkg;

    localparam int TABLE_SIZE  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int MCNT_W      = $clog2(MAX_RESULTS);

    localparam int KEY_W  = 31;
    localparam int NAME_W = 64;
    localparam int LOC_W  = 64;
    localparam int MGR_W  = 32;
    localparam int ADM_W  = 32;
    localparam int WILD_W = 5;

    // Operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_SELECT = 2'd2;
    localparam logic [1:0] FUNC_DELETE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Wildcard bit positions
    localparam int WB_KEY  = 0;
    localparam int WB_NAME = 1;
    localparam int WB_LOC  = 2;
    localparam int WB_MGR  = 3;
    localparam int WB_ADM  = 4;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [LOC_W-1:0]  loc;
        logic [MGR_W-1:0]  mgr;
        logic [ADM_W-1:0]  adm;
    } record_t;

    typedef enum logic [1:0] {
        SRC_INPUT = 2'd0,
        SRC_PEND  = 2'd1,
        SRC_NONE  = 2'd2
    } emit_src_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       advance;
        logic       write;
        logic       take_match;
        logic       clear_valid;
        logic       emit;
        emit_src_t  src;
        logic [1:0] status;
        logic       last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic probe_op;
        logic is_insert;
        logic is_delete;
        logic hit;
        logic last_slot;
        logic cap_next;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/linear_probe_record_table_unit.sv =====
// Top level: linear probe record table with controller and datapath.
// Insert and update probe from the home slot, a read state then a check state per probed slot,
// and stop at the first hit (a free slot for insert, the key for update). Select and delete
// visit every slot the same way, then release the final result from the flush state.
// One transaction in flight: the next is taken only once the slot walk is done (in_stall).
// Reset: rst_n clears all valid bits at once, so the table is empty straight after reset.
`timescale 1ns / 1ps

module linear_probe_record_table_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [lprt_pkg::KEY_W-1:0]    key_id,
    input  logic [lprt_pkg::NAME_W-1:0]   name_code,
    input  logic [lprt_pkg::LOC_W-1:0]    location_code,
    input  logic [lprt_pkg::MGR_W-1:0]    manager_id,
    input  logic [lprt_pkg::ADM_W-1:0]    admin_id,
    input  logic [lprt_pkg::WILD_W-1:0]   wildcard_mask,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [3:0]                    slot,
    output logic [lprt_pkg::KEY_W-1:0]    out_key,
    output logic [lprt_pkg::NAME_W-1:0]   out_name,
    output logic [lprt_pkg::LOC_W-1:0]    out_location,
    output logic [lprt_pkg::MGR_W-1:0]    out_manager,
    output logic [lprt_pkg::ADM_W-1:0]    out_admin,
    output logic                          last
);

    // Command and status groups between the controller and the datapath
    lprt_pkg::cmd_t cmd;
    lprt_pkg::sts_t sts;

    // The controller walks the slots: a read state, then a check state per slot.
    // Insert and update stop at the first hit; select and delete keep one match
    // parked so that the final one can be released with last set.
    lprt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the record memory, the valid bits, the probe pointer
    // and the result register that parts the result port from the slot walk.
    lprt_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .key_id        (key_id),
        .name_code     (name_code),
        .location_code (location_code),
        .manager_id    (manager_id),
        .admin_id      (admin_id),
        .wildcard_mask (wildcard_mask),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .slot          (slot),
        .out_key       (out_key),
        .out_name      (out_name),
        .out_location  (out_location),
        .out_manager   (out_manager),
        .out_admin     (out_admin),
        .last          (last)
    );

endmodule

// ===== hdl/lprt_dp.sv =====
// Datapath: record memory, valid bits, probe pointer, pending match and result register.
`timescale 1ns / 1ps

module lprt_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    func,
    input  logic [lprt_pkg::KEY_W-1:0]    key_id,
    input  logic [lprt_pkg::NAME_W-1:0]   name_code,
    input  logic [lprt_pkg::LOC_W-1:0]    location_code,
    input  logic [lprt_pkg::MGR_W-1:0]    manager_id,
    input  logic [lprt_pkg::ADM_W-1:0]    admin_id,
    input  logic [lprt_pkg::WILD_W-1:0]   wildcard_mask,
    input  lprt_pkg::cmd_t                cmd,
    output lprt_pkg::sts_t                sts,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [1:0]                    status,
    output logic [3:0]                    slot,
    output logic [lprt_pkg::KEY_W-1:0]    out_key,
    output logic [lprt_pkg::NAME_W-1:0]   out_name,
    output logic [lprt_pkg::LOC_W-1:0]    out_location,
    output logic [lprt_pkg::MGR_W-1:0]    out_manager,
    output logic [lprt_pkg::ADM_W-1:0]    out_admin,
    output logic                          last
);

    lprt_pkg::record_t mem [lprt_pkg::TABLE_SIZE];
    lprt_pkg::record_t rd_reg;
    lprt_pkg::record_t item_reg;
    lprt_pkg::record_t pend_rec_reg;
    lprt_pkg::record_t out_rec_reg;

    logic [1:0]                      func_reg;
    logic [lprt_pkg::WILD_W-1:0]     wild_reg;
    logic [lprt_pkg::TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [lprt_pkg::SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [lprt_pkg::SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [lprt_pkg::MCNT_W-1:0]     mcnt_reg, mcnt_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [lprt_pkg::SLOT_W-1:0]     pend_slot_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [1:0]                      out_status_reg;
    logic [lprt_pkg::SLOT_W-1:0]     out_slot_reg;
    logic                            out_last_reg;

    logic probe_op;
    logic key_eq, name_ok, loc_ok, mgr_ok, adm_ok;
    logic scan_hit;

    assign probe_op = (func_reg == lprt_pkg::FUNC_INSERT) ||
                      (func_reg == lprt_pkg::FUNC_UPDATE);

    assign key_eq  = (rd_reg.key == item_reg.key);
    assign name_ok = wild_reg[lprt_pkg::WB_NAME] || (rd_reg.name == item_reg.name);
    assign loc_ok  = wild_reg[lprt_pkg::WB_LOC]  || (rd_reg.loc  == item_reg.loc);
    assign mgr_ok  = wild_reg[lprt_pkg::WB_MGR]  || (rd_reg.mgr  == item_reg.mgr);
    assign adm_ok  = wild_reg[lprt_pkg::WB_ADM]  || (rd_reg.adm  == item_reg.adm);
    assign scan_hit = valid_reg[ptr_reg] && (wild_reg[lprt_pkg::WB_KEY] || key_eq) &&
                      name_ok && loc_ok && mgr_ok && adm_ok;

    always_comb
    begin
        sts.probe_op   = probe_op;
        sts.is_insert  = (func_reg == lprt_pkg::FUNC_INSERT);
        sts.is_delete  = (func_reg == lprt_pkg::FUNC_DELETE);
        if (func_reg == lprt_pkg::FUNC_INSERT)
        begin
            sts.hit = !valid_reg[ptr_reg];
        end
        else if (func_reg == lprt_pkg::FUNC_UPDATE)
        begin
            sts.hit = valid_reg[ptr_reg] && key_eq;
        end
        else
        begin
            sts.hit = scan_hit;
        end
        sts.last_slot  = (cnt_reg == lprt_pkg::SLOT_W'(lprt_pkg::TABLE_SIZE - 1));
        sts.cap_next   = (mcnt_reg == lprt_pkg::MCNT_W'(lprt_pkg::MAX_RESULTS - 1));
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // Control state next values
    always_comb
    begin
        valid_next      = valid_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        mcnt_next       = mcnt_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            // Probes start at the home slot, scans at slot zero
            if ((func == lprt_pkg::FUNC_INSERT) || (func == lprt_pkg::FUNC_UPDATE))
            begin
                ptr_next = key_id[lprt_pkg::SLOT_W-1:0];
            end
            else
            begin
                ptr_next = '0;
            end
            cnt_next        = '0;
            mcnt_next       = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.advance)
        begin
            if (ptr_reg == lprt_pkg::SLOT_W'(lprt_pkg::TABLE_SIZE - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.write)
        begin
            valid_next[ptr_reg] = 1'b1;
        end
        if (cmd.clear_valid)
        begin
            valid_next[ptr_reg] = 1'b0;
        end
        if (cmd.take_match)
        begin
            pend_valid_next = 1'b1;
            mcnt_next       = mcnt_reg + 1'b1;
        end
        else if (cmd.emit && (cmd.src == lprt_pkg::SRC_PEND))
        begin
            pend_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            mcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            mcnt_reg       <= mcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Record memory: one write port, one registered read port at the probe pointer
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[ptr_reg] <= item_reg;
        end
        rd_reg <= mem[ptr_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= func;
            wild_reg      <= wildcard_mask;
            item_reg.key  <= key_id;
            item_reg.name <= name_code;
            item_reg.loc  <= location_code;
            item_reg.mgr  <= manager_id;
            item_reg.adm  <= admin_id;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            out_last_reg   <= cmd.last;
            case (cmd.src)
                lprt_pkg::SRC_INPUT:
                begin
                    out_slot_reg <= ptr_reg;
                    out_rec_reg  <= item_reg;
                end
                lprt_pkg::SRC_PEND:
                begin
                    out_slot_reg <= pend_slot_reg;
                    out_rec_reg  <= pend_rec_reg;
                end
                default:
                begin
                    out_slot_reg <= '0;
                    out_rec_reg  <= '0;
                end
            endcase
        end
        if (cmd.take_match)
        begin
            pend_slot_reg <= ptr_reg;
            pend_rec_reg  <= rd_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot         = 4'(out_slot_reg);
    assign out_key      = out_rec_reg.key;
    assign out_name     = out_rec_reg.name;
    assign out_location = out_rec_reg.loc;
    assign out_manager  = out_rec_reg.mgr;
    assign out_admin    = out_rec_reg.adm;
    assign last         = out_last_reg;

endmodule

// ===== hdl/lprt_ctrl.sv =====
// Controller: state machine that sequences probes and scans over the table slots.
`timescale 1ns / 1ps

module lprt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lprt_pkg::sts_t sts,
    output lprt_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.src         = lprt_pkg::SRC_NONE;
        cmd.status      = lprt_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.probe_op)
                begin
                    if (sts.hit)
                    begin
                        // Hold until the result register frees up
                        if (sts.out_free)
                        begin
                            cmd.write  = 1'b1;
                            cmd.emit   = 1'b1;
                            cmd.src    = lprt_pkg::SRC_INPUT;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (sts.last_slot)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.src    = lprt_pkg::SRC_NONE;
                            cmd.status = sts.is_insert ? lprt_pkg::ST_FULL
                                                       : lprt_pkg::ST_NOT_FOUND;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else
                begin
                    if (sts.hit)
                    begin
                        if (!sts.pend_valid || sts.out_free)
                        begin
                            // Release the previous match, park this one
                            cmd.emit        = sts.pend_valid;
                            cmd.src         = lprt_pkg::SRC_PEND;
                            cmd.take_match  = 1'b1;
                            cmd.clear_valid = sts.is_delete;
                            if (sts.last_slot || sts.cap_next)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                cmd.advance = 1'b1;
                                state_next  = S_READ;
                            end
                        end
                    end
                    else if (sts.last_slot)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.src    = sts.pend_valid ? lprt_pkg::SRC_PEND : lprt_pkg::SRC_NONE;
                    cmd.status = sts.pend_valid ? lprt_pkg::ST_OK : lprt_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/lprt_chk.sv =====
// Checker: port-level assertions for the record table, bound to the top level.
`timescale 1ns / 1ps

module lprt_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [3:0]                    slot,
    input logic [lprt_pkg::KEY_W-1:0]    out_key,
    input logic [lprt_pkg::NAME_W-1:0]   out_name,
    input logic                          last
);

    // An accepted transaction raises in_stall in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken in the cycle after an accepted transaction");

    // A stalled result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(slot) &&
                                      $stable(out_key) && $stable(last)))
        else $error("stalled result changed");

    // A failure result closes its transaction and carries no record
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != lprt_pkg::ST_OK)) |->
            (last && (slot == 4'd0) && (out_key == '0) && (out_name == '0)))
        else $error("failure result without last or with record data");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == lprt_pkg::ST_OK) || (status == lprt_pkg::ST_FULL) ||
                       (status == lprt_pkg::ST_NOT_FOUND)))
        else $error("undefined status code");

endmodule

bind linear_probe_record_table_unit lprt_chk u_lprt_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot      (slot),
    .out_key   (out_key),
    .out_name  (out_name),
    .last      (last)
);
